// ----- rtl/core/cpz_pkg.sv -----
// Shared constants, codes and types for the polynomial zero table.
`timescale 1ns / 1ps
package cpz_pkg;

  localparam int MAX_ZEROS_DEF = 16;
  localparam int MAX_ORDER_DEF = 15;
  localparam int FRAC_BITS_DEF = 12;
  localparam int OUT_FRAC      = 24;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_EVAL   = 2'd2;
  localparam logic [1:0] REQ_SYM    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_SAT       = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS_UPD,
    OP_INS_NEW,
    OP_SET_FULL,
    OP_SET_NF,
    OP_HOLD_ENTRY,
    OP_WRITE_HOLD,
    OP_DEL_DONE,
    OP_FAC1,
    OP_FAC2,
    OP_MUL,
    OP_RND,
    OP_KEY_SYM,
    OP_SYM_FAIL,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       match;
    logic       im_zero;
    logic       ord_eq;
  } dp_sts_t;

  function automatic logic [16:0] mag16(logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return e[16] ? 17'(-e) : 17'(e);
  endfunction

endpackage

// ----- rtl/core/cpz_datapath.sv -----
// Zero storage, matching, factor and product arithmetic, result registers.
`timescale 1ns / 1ps
module cpz_datapath #(
  parameter int MAX_ZEROS = cpz_pkg::MAX_ZEROS_DEF,
  parameter int MAX_ORDER = cpz_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS = cpz_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  cpz_pkg::dp_cmd_t                         cmd_i,
  input  logic [(MAX_ZEROS > 1 ? $clog2(MAX_ZEROS) : 1)-1:0] idx_i,
  input  logic [1:0]                               req_type_i,
  input  logic signed [15:0]                       zero_real_i,
  input  logic signed [15:0]                       zero_imag_i,
  input  logic [3:0]                               zero_order_i,
  input  logic signed [15:0]                       point_u_i,
  output cpz_pkg::dp_sts_t                         sts_o,
  output logic [$clog2(MAX_ZEROS+1)-1:0]           count_o,
  output logic [$clog2(MAX_ORDER+1)-1:0]           ord_o,
  output logic [1:0]                               status_o,
  output logic                                     changed_o,
  output logic signed [63:0]                       poly_value_o,
  output logic                                     is_symmetric_o,
  output logic [$clog2(MAX_ZEROS+1)-1:0]           zero_count_o
);

  localparam int CW = $clog2(MAX_ZEROS + 1);
  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam int OF = cpz_pkg::OUT_FRAC;
  localparam int SR = (2 * FRAC_BITS > OF) ? 2 * FRAC_BITS - OF : 0;
  localparam int SL = (2 * FRAC_BITS < OF) ? OF - 2 * FRAC_BITS : 0;

  logic signed [15:0] re_q [MAX_ZEROS];
  logic signed [15:0] im_q [MAX_ZEROS];
  logic [OW-1:0]      ord_q [MAX_ZEROS];

  logic signed [15:0] rd_re, rd_im;
  logic [OW-1:0]      rd_ord;
  logic [16:0]        im_mag;

  logic [CW-1:0]      count_q;
  logic               change_q;
  logic [1:0]         req_q;
  logic signed [16:0] key_re_q;
  logic signed [15:0] key_im_q;
  logic signed [15:0] u_q;
  logic [OW-1:0]      ordr_q;
  logic signed [15:0] hold_re_q, hold_im_q;
  logic [OW-1:0]      hold_ord_q;
  logic [1:0]         status_q;
  logic               sym_q;
  logic [63:0]        prod_q;
  logic [31:0]        sq_q;
  logic [15:0]        imag_q;
  logic [63:0]        f_mag_q;
  logic               f_neg_q;
  logic [127:0]       acc_q;
  logic [1:0]         out_status_q;
  logic               out_changed_q;
  logic [63:0]        out_poly_q;
  logic               out_sym_q;
  logic [CW-1:0]      out_count_q;

  logic [7:0]         ord_clamp;
  logic signed [16:0] diff;
  logic [16:0]        diff_mag;
  logic [32:0]        sq_sum;
  logic [65:0]        scaled;
  logic [63:0]        a_mag;
  logic [63:0]        pp;
  logic [127:0]       pp_sh;
  logic [127:0]       rnd_sum;
  logic [103:0]       rnd_val;
  logic [103:0]       lim;
  logic               neg;
  logic               sat;
  logic [63:0]        res_mag;

  assign rd_re  = re_q[idx_i];
  assign rd_im  = im_q[idx_i];
  assign rd_ord = ord_q[idx_i];
  assign im_mag = cpz_pkg::mag16(rd_im);

  assign sts_o.req     = req_q;
  assign sts_o.match   = ({rd_re[15], rd_re} == key_re_q) &&
                         (im_mag == cpz_pkg::mag16(key_im_q));
  assign sts_o.im_zero = (rd_im == 16'sd0);
  assign sts_o.ord_eq  = (rd_ord == ordr_q);
  assign count_o       = count_q;
  assign ord_o         = rd_ord;

  always_comb begin
    ord_clamp = {4'b0, zero_order_i};
    if (ord_clamp == 8'd0) begin
      ord_clamp = 8'd1;
    end
    if (ord_clamp > 8'(MAX_ORDER)) begin
      ord_clamp = 8'(MAX_ORDER);
    end
  end

  always_comb begin
    diff     = {u_q[15], u_q} - {rd_re[15], rd_re};
    diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
    sq_sum   = 33'(sq_q) + 33'(imag_q * imag_q);
    scaled   = ((({32'b0, sq_sum, 1'b0}) + (66'd1 << SR)) >> (SR + 1)) << SL;
  end

  always_comb begin
    a_mag = prod_q[63] ? 64'(-prod_q) : prod_q;
    case (cmd_i.step)
      2'd0:    pp = 64'(a_mag[31:0]) * 64'(f_mag_q[31:0]);
      2'd1:    pp = 64'(a_mag[31:0]) * 64'(f_mag_q[63:32]);
      2'd2:    pp = 64'(a_mag[63:32]) * 64'(f_mag_q[31:0]);
      default: pp = 64'(a_mag[63:32]) * 64'(f_mag_q[63:32]);
    endcase
    case (cmd_i.step)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
  end

  always_comb begin
    neg     = prod_q[63] ^ f_neg_q;
    rnd_sum = acc_q + (128'd1 << (OF - 1));
    rnd_val = rnd_sum[127:OF];
    lim     = neg ? (104'd1 << 63) : ((104'd1 << 63) - 104'd1);
    sat     = rnd_val > lim;
    res_mag = sat ? lim[63:0] : rnd_val[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      change_q <= 1'b0;
    end else begin
      unique case (cmd_i.op) inside
        cpz_pkg::OP_INS_UPD: begin
          change_q <= (rd_ord < ordr_q);
        end
        cpz_pkg::OP_INS_NEW: begin
          count_q  <= count_q + CW'(1);
          change_q <= 1'b1;
        end
        cpz_pkg::OP_SET_FULL, cpz_pkg::OP_SET_NF: begin
          change_q <= 1'b0;
        end
        cpz_pkg::OP_DEL_DONE: begin
          count_q  <= count_q - CW'(1);
          change_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      cpz_pkg::OP_LOAD: begin
        req_q    <= req_type_i;
        key_re_q <= {zero_real_i[15], zero_real_i};
        key_im_q <= zero_imag_i;
        u_q      <= point_u_i;
        ordr_q   <= ord_clamp[OW-1:0];
        status_q <= cpz_pkg::ST_OK;
        prod_q   <= 64'd1 << OF;
        sym_q    <= (count_q != '0);
      end
      cpz_pkg::OP_INS_UPD: begin
        if (rd_ord < ordr_q) begin
          ord_q[idx_i] <= ordr_q;
        end
      end
      cpz_pkg::OP_INS_NEW: begin
        re_q[idx_i]  <= key_re_q[15:0];
        im_q[idx_i]  <= key_im_q;
        ord_q[idx_i] <= ordr_q;
      end
      cpz_pkg::OP_SET_FULL: status_q <= cpz_pkg::ST_FULL;
      cpz_pkg::OP_SET_NF:   status_q <= cpz_pkg::ST_NOT_FOUND;
      cpz_pkg::OP_HOLD_ENTRY: begin
        hold_re_q  <= rd_re;
        hold_im_q  <= rd_im;
        hold_ord_q <= rd_ord;
      end
      cpz_pkg::OP_WRITE_HOLD: begin
        re_q[idx_i]  <= hold_re_q;
        im_q[idx_i]  <= hold_im_q;
        ord_q[idx_i] <= hold_ord_q;
      end
      cpz_pkg::OP_FAC1: begin
        sq_q    <= 32'(diff_mag[15:0]) * 32'(diff_mag[15:0]);
        imag_q  <= im_mag[15:0];
        f_mag_q <= 64'(diff_mag[15:0]) << (OF - FRAC_BITS);
        f_neg_q <= diff[16];
      end
      cpz_pkg::OP_FAC2: begin
        f_mag_q <= scaled[63:0];
        f_neg_q <= 1'b0;
      end
      cpz_pkg::OP_MUL: begin
        acc_q <= (cmd_i.step == 2'd0) ? pp_sh : acc_q + pp_sh;
      end
      cpz_pkg::OP_RND: begin
        prod_q <= neg ? 64'(-res_mag) : res_mag;
        if (sat) begin
          status_q <= cpz_pkg::ST_SAT;
        end
      end
      cpz_pkg::OP_KEY_SYM: begin
        key_re_q <= -{rd_re[15], rd_re};
        key_im_q <= 16'sd0;
        ordr_q   <= rd_ord;
      end
      cpz_pkg::OP_SYM_FAIL: sym_q <= 1'b0;
      cpz_pkg::OP_OUT: begin
        out_status_q  <= status_q;
        out_changed_q <= change_q;
        out_poly_q    <= (req_q == cpz_pkg::REQ_EVAL) ? prod_q : 64'd0;
        out_sym_q     <= (req_q == cpz_pkg::REQ_SYM) ? sym_q : 1'b0;
        out_count_q   <= count_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o       = out_status_q;
  assign changed_o      = out_changed_q;
  assign poly_value_o   = out_poly_q;
  assign is_symmetric_o = out_sym_q;
  assign zero_count_o   = out_count_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ZEROS))
    else $error("zero count beyond table depth");

  a_new_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == cpz_pkg::OP_INS_NEW) |-> (count_q < CW'(MAX_ZEROS)))
    else $error("insert into full table");

  a_del_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == cpz_pkg::OP_DEL_DONE) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("delete did not drop count");

endmodule

// ----- rtl/core/cpz_ctrl.sv -----
// Sequencer for scan, shift, evaluate and symmetry passes and result handoff.
`timescale 1ns / 1ps
module cpz_ctrl #(
  parameter int MAX_ZEROS = cpz_pkg::MAX_ZEROS_DEF,
  parameter int MAX_ORDER = cpz_pkg::MAX_ORDER_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [1:0]                               req_type_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  input  cpz_pkg::dp_sts_t                         sts_i,
  input  logic [$clog2(MAX_ZEROS+1)-1:0]           count_i,
  input  logic [$clog2(MAX_ORDER+1)-1:0]           ord_i,
  output cpz_pkg::dp_cmd_t                         cmd_o,
  output logic [(MAX_ZEROS > 1 ? $clog2(MAX_ZEROS) : 1)-1:0] idx_o
);

  localparam int IW = (MAX_ZEROS > 1) ? $clog2(MAX_ZEROS) : 1;
  localparam int CW = $clog2(MAX_ZEROS + 1);
  localparam int OW = $clog2(MAX_ORDER + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_SHIFT_RD = 4'd2;
  localparam logic [3:0] S_SHIFT_WR = 4'd3;
  localparam logic [3:0] S_FAC1     = 4'd4;
  localparam logic [3:0] S_FAC2     = 4'd5;
  localparam logic [3:0] S_MUL      = 4'd6;
  localparam logic [3:0] S_RND      = 4'd7;
  localparam logic [3:0] S_SYM_K    = 4'd8;
  localparam logic [3:0] S_SYM_P    = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] k_q, k_d, p_q, p_d;
  logic [CW:0]   kp1;
  logic [OW-1:0] n_q, n_d;
  logic [1:0]    step_q, step_d;
  logic          out_valid_q, out_valid_d;
  logic          full;

  assign kp1  = {1'b0, k_q} + (CW+1)'(1);
  assign full = (count_i == CW'(MAX_ZEROS));

  always_comb begin
    if (state_q == S_SYM_P) begin
      idx_o = p_q[IW-1:0];
    end else if (state_q == S_SHIFT_RD) begin
      idx_o = kp1[IW-1:0];
    end else begin
      idx_o = k_q[IW-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    p_d        = p_q;
    n_d        = n_q;
    step_d     = step_q;
    cmd_o.op   = cpz_pkg::OP_NONE;
    cmd_o.step = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = cpz_pkg::OP_LOAD;
          k_d      = '0;
          unique case (req_type_i) inside
            cpz_pkg::REQ_INSERT, cpz_pkg::REQ_DELETE: state_d = S_SCAN;
            cpz_pkg::REQ_EVAL: state_d = (count_i == '0) ? S_DONE : S_FAC1;
            default:           state_d = (count_i == '0) ? S_DONE : S_SYM_K;
          endcase
        end
      end
      S_SCAN: begin
        if (k_q == count_i) begin
          if (sts_i.req == cpz_pkg::REQ_INSERT) begin
            cmd_o.op = full ? cpz_pkg::OP_SET_FULL : cpz_pkg::OP_INS_NEW;
          end else begin
            cmd_o.op = cpz_pkg::OP_SET_NF;
          end
          state_d = S_DONE;
        end else if (sts_i.match) begin
          if (sts_i.req == cpz_pkg::REQ_INSERT) begin
            cmd_o.op = cpz_pkg::OP_INS_UPD;
            state_d  = S_DONE;
          end else begin
            state_d = S_SHIFT_RD;
          end
        end else begin
          k_d = k_q + CW'(1);
        end
      end
      S_SHIFT_RD: begin
        if (kp1 < {1'b0, count_i}) begin
          cmd_o.op = cpz_pkg::OP_HOLD_ENTRY;
          state_d  = S_SHIFT_WR;
        end else begin
          cmd_o.op = cpz_pkg::OP_DEL_DONE;
          state_d  = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.op = cpz_pkg::OP_WRITE_HOLD;
        k_d      = k_q + CW'(1);
        state_d  = S_SHIFT_RD;
      end
      S_FAC1: begin
        cmd_o.op = cpz_pkg::OP_FAC1;
        n_d      = '0;
        step_d   = 2'd0;
        state_d  = sts_i.im_zero ? S_MUL : S_FAC2;
      end
      S_FAC2: begin
        cmd_o.op = cpz_pkg::OP_FAC2;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = cpz_pkg::OP_MUL;
        step_d   = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        cmd_o.op = cpz_pkg::OP_RND;
        step_d   = 2'd0;
        if (({1'b0, n_q} + (OW+1)'(1)) < {1'b0, ord_i}) begin
          n_d     = n_q + OW'(1);
          state_d = S_MUL;
        end else if (kp1 == {1'b0, count_i}) begin
          state_d = S_DONE;
        end else begin
          k_d     = k_q + CW'(1);
          state_d = S_FAC1;
        end
      end
      S_SYM_K: begin
        if (k_q == count_i) begin
          state_d = S_DONE;
        end else if (sts_i.im_zero) begin
          cmd_o.op = cpz_pkg::OP_KEY_SYM;
          p_d      = '0;
          state_d  = S_SYM_P;
        end else begin
          k_d = k_q + CW'(1);
        end
      end
      S_SYM_P: begin
        if (p_q == count_i) begin
          cmd_o.op = cpz_pkg::OP_SYM_FAIL;
          state_d  = S_DONE;
        end else if (sts_i.match) begin
          if (sts_i.ord_eq) begin
            k_d     = k_q + CW'(1);
            state_d = S_SYM_K;
          end else begin
            cmd_o.op = cpz_pkg::OP_SYM_FAIL;
            state_d  = S_DONE;
          end
        end else begin
          p_d = p_q + CW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op = cpz_pkg::OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == cpz_pkg::OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      p_q         <= '0;
      n_q         <= '0;
      step_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      p_q         <= p_d;
      n_q         <= n_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted beat left sequencer idle");

  a_done_free_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not handed off");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_SYM_K) |-> (k_q <= count_i))
    else $error("scan index past fill");

endmodule

// ----- rtl/core/characteristic_polynomial_zero_table.sv -----
// Top level of the polynomial zero table: sequencer plus datapath.
//
//   channel | direction | handshake            | beat payload
//   in      | input     | in_valid_i/in_stall_o   | req_type, zero_real, zero_imag, zero_order, point_u
//   out     | output    | out_valid_o/out_stall_i | status, changed, poly_value, is_symmetric, zero_count
//
// Insert/delete: scan the entries in turn until a match or the fill count; delete then
// shifts each later entry down (S_SHIFT_RD, S_SHIFT_WR). Evaluate: per entry a factor
// (plus a second step for a complex zero), then per order unit four 32x32 partial products
// and a round/saturate step on the shared multiplier. Symmetry: single-port table reads.
// Reset clears fill count, change flag and sequencer; no table clearing pass.
// A new beat is taken while a finished result still waits on out_stall_i.
`timescale 1ns / 1ps
module characteristic_polynomial_zero_table #(
  parameter int MAX_ZEROS = cpz_pkg::MAX_ZEROS_DEF,
  parameter int MAX_ORDER = cpz_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS = cpz_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     req_type_i,
  input  logic signed [15:0]             zero_real_i,
  input  logic signed [15:0]             zero_imag_i,
  input  logic [3:0]                     zero_order_i,
  input  logic signed [15:0]             point_u_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic                           changed_o,
  output logic signed [63:0]             poly_value_o,
  output logic                           is_symmetric_o,
  output logic [$clog2(MAX_ZEROS+1)-1:0] zero_count_o
);

  localparam int IW = (MAX_ZEROS > 1) ? $clog2(MAX_ZEROS) : 1;
  localparam int CW = $clog2(MAX_ZEROS + 1);
  localparam int OW = $clog2(MAX_ORDER + 1);

  cpz_pkg::dp_cmd_t cmd;
  cpz_pkg::dp_sts_t sts;
  logic [IW-1:0]    idx;
  logic [CW-1:0]    count;
  logic [OW-1:0]    ord;

  cpz_ctrl #(
    .MAX_ZEROS(MAX_ZEROS),
    .MAX_ORDER(MAX_ORDER)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .count_i    (count),
    .ord_i      (ord),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  cpz_datapath #(
    .MAX_ZEROS(MAX_ZEROS),
    .MAX_ORDER(MAX_ORDER),
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .idx_i         (idx),
    .req_type_i    (req_type_i),
    .zero_real_i   (zero_real_i),
    .zero_imag_i   (zero_imag_i),
    .zero_order_i  (zero_order_i),
    .point_u_i     (point_u_i),
    .sts_o         (sts),
    .count_o       (count),
    .ord_o         (ord),
    .status_o      (status_o),
    .changed_o     (changed_o),
    .poly_value_o  (poly_value_o),
    .is_symmetric_o(is_symmetric_o),
    .zero_count_o  (zero_count_o)
  );

endmodule
